[hw/rtl/assert_macros.svh]
// Assertion macros shared by the blink scheduler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Expression never holds.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/lbs_pkg.sv]
// Shared types and constants of the LED blink scheduler.
package lbs_pkg;

  localparam int SLOTS_DEF = 8;

  localparam int LED_W   = 8;
  localparam int COLOR_W = 8;
  localparam int CNT_W   = 16;

  localparam int CFG_W = LED_W + 3 * COLOR_W + 2 * CNT_W;
  localparam int DYN_W = 2 * CNT_W;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic flush;
  } dp_ctrl_t;

endpackage

[hw/rtl/lbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/lbs_ctrl.sv]
// Controller: sequences one slot scan per accepted item.
`include "assert_macros.svh"

module lbs_ctrl #(
  parameter int SLOTS = lbs_pkg::SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output lbs_pkg::dp_ctrl_t ctrl,
  output logic [IDX_W-1:0]  rd_idx
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FLUSH
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t           state_r;
  logic [IDX_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_SCAN;
            idx_r   <= '0;
          end
        end
        S_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_FLUSH;
        end
        S_FLUSH: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign ctrl.load  = start && !busy;
  assign ctrl.rd_en = (state_r == S_SCAN);
  assign ctrl.flush = (state_r == S_FLUSH);
  assign rd_idx     = idx_r;

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `ASSERT_NEXT(a_flush_idle, ctrl.flush, !busy, "scan did not end after flush")

endmodule

[hw/rtl/lbs_dp.sv]
// Datapath: slot tables, per-slot update and result ordering.
`include "assert_macros.svh"

module lbs_dp #(
  parameter int SLOTS = lbs_pkg::SLOTS_DEF,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lbs_pkg::dp_ctrl_t           ctrl,
  input  logic [IDX_W-1:0]            rd_idx,
  input  logic [1:0]                  in_cmd,
  input  logic [lbs_pkg::LED_W-1:0]   in_led_index,
  input  logic [lbs_pkg::COLOR_W-1:0] in_red,
  input  logic [lbs_pkg::COLOR_W-1:0] in_green,
  input  logic [lbs_pkg::COLOR_W-1:0] in_blue,
  input  logic [lbs_pkg::CNT_W-1:0]   in_blink_count,
  input  logic [lbs_pkg::CNT_W-1:0]   in_on_frames,
  input  logic [lbs_pkg::CNT_W-1:0]   in_off_frames,
  output logic                        out_strobe,
  output logic [lbs_pkg::LED_W-1:0]   out_led_index_res,
  output logic [lbs_pkg::COLOR_W-1:0] out_red_res,
  output logic [lbs_pkg::COLOR_W-1:0] out_green_res,
  output logic [lbs_pkg::COLOR_W-1:0] out_blue_res,
  output logic                        out_last
);

  localparam int CW = lbs_pkg::CNT_W;
  localparam int KW = lbs_pkg::COLOR_W;
  localparam int LW = lbs_pkg::LED_W;

  lbs_pkg::cmd_t cmd_r;
  logic [LW-1:0] new_led_r;
  logic [KW-1:0] new_red_r, new_green_r, new_blue_r;
  logic [CW-1:0] new_count_r, new_on_r, new_off_r;

  logic [SLOTS-1:0] active_r, active_nxt;
  logic [SLOTS-1:0] lit_r, lit_nxt;
  logic [SLOTS-1:0] written_r, written_nxt;
  logic             claimed_r, claimed_nxt;

  logic             proc_v_r;
  logic [IDX_W-1:0] proc_idx_r;

  logic          pend_v_r;
  logic [LW-1:0] pend_led_r;
  logic [KW-1:0] pend_red_r, pend_green_r, pend_blue_r;

  logic          out_strobe_r, out_last_r;
  logic [LW-1:0] out_led_r;
  logic [KW-1:0] out_red_r, out_green_r, out_blue_r;

  logic                       cfg_we, dyn_we;
  logic [lbs_pkg::CFG_W-1:0]  cfg_wdata, cfg_rd, cfg_q;
  logic [lbs_pkg::DYN_W-1:0]  dyn_wdata, dyn_rd, dyn_q;

  logic [LW-1:0] q_led;
  logic [KW-1:0] q_red, q_green, q_blue;
  logic [CW-1:0] q_on, q_off, q_rem, q_ticks;
  logic [CW-1:0] t_inc, t_new, rem_dec, rem_new;
  logic          cur_active, cur_lit, cur_written;
  logic          lit_new, act_new;

  logic          emit;
  logic [KW-1:0] emit_red, emit_green, emit_blue;

  assign cfg_wdata = {new_led_r, new_red_r, new_green_r, new_blue_r, new_on_r, new_off_r};

  lbs_ram #(
    .WIDTH (lbs_pkg::CFG_W),
    .DEPTH (SLOTS)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (proc_idx_r),
    .wdata (cfg_wdata),
    .raddr (rd_idx),
    .rdata (cfg_rd)
  );

  lbs_ram #(
    .WIDTH (lbs_pkg::DYN_W),
    .DEPTH (SLOTS)
  ) u_dyn_ram (
    .clk   (clk),
    .we    (dyn_we),
    .waddr (proc_idx_r),
    .wdata (dyn_wdata),
    .raddr (rd_idx),
    .rdata (dyn_rd)
  );

  assign cur_written = written_r[proc_idx_r];
  assign cur_active  = active_r[proc_idx_r];
  assign cur_lit     = lit_r[proc_idx_r];
  assign cfg_q       = cur_written ? cfg_rd : '0;
  assign dyn_q       = cur_written ? dyn_rd : '0;

  assign q_led   = cfg_q[lbs_pkg::CFG_W-1 -: LW];
  assign q_red   = cfg_q[3*KW+2*CW-1 -: KW];
  assign q_green = cfg_q[2*KW+2*CW-1 -: KW];
  assign q_blue  = cfg_q[KW+2*CW-1 -: KW];
  assign q_on    = cfg_q[2*CW-1 -: CW];
  assign q_off   = cfg_q[CW-1:0];
  assign q_rem   = dyn_q[2*CW-1 -: CW];
  assign q_ticks = dyn_q[CW-1:0];

  assign t_inc   = q_ticks + CW'(1);
  assign rem_dec = q_rem - CW'(1);

  always_comb begin
    cfg_we      = 1'b0;
    dyn_we      = 1'b0;
    dyn_wdata   = {new_count_r, CW'(0)};
    active_nxt  = active_r;
    lit_nxt     = lit_r;
    written_nxt = written_r;
    claimed_nxt = claimed_r;
    emit        = 1'b0;
    emit_red    = '0;
    emit_green  = '0;
    emit_blue   = '0;
    t_new       = t_inc;
    rem_new     = q_rem;
    lit_new     = cur_lit;
    act_new     = 1'b1;
    if (cur_lit) begin
      if (t_inc >= q_on) begin
        t_new   = '0;
        lit_new = 1'b0;
        if (q_rem != '0) begin
          rem_new = rem_dec;
          if (rem_dec == '0) begin
            act_new = 1'b0;
          end
        end
      end
    end else if (t_inc >= q_off) begin
      t_new   = '0;
      lit_new = 1'b1;
    end
    if (proc_v_r) begin
      unique case (cmd_r)
        lbs_pkg::CMD_START: begin
          if (!cur_active && !claimed_r) begin
            cfg_we                  = 1'b1;
            dyn_we                  = 1'b1;
            active_nxt[proc_idx_r]  = 1'b1;
            lit_nxt[proc_idx_r]     = 1'b1;
            written_nxt[proc_idx_r] = 1'b1;
            claimed_nxt             = 1'b1;
          end
        end
        lbs_pkg::CMD_TICK: begin
          if (cur_active) begin
            dyn_we                 = 1'b1;
            dyn_wdata              = {rem_new, t_new};
            active_nxt[proc_idx_r] = act_new;
            lit_nxt[proc_idx_r]    = lit_new;
            emit                   = 1'b1;
            if (lit_new) begin
              emit_red   = q_red;
              emit_green = q_green;
              emit_blue  = q_blue;
            end
          end
        end
        lbs_pkg::CMD_STOP: begin
          active_nxt[proc_idx_r] = 1'b0;
          lit_nxt[proc_idx_r]    = 1'b0;
          emit                   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      lit_r        <= '0;
      written_r    <= '0;
      claimed_r    <= 1'b0;
      proc_v_r     <= 1'b0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      active_r     <= active_nxt;
      lit_r        <= lit_nxt;
      written_r    <= written_nxt;
      claimed_r    <= ctrl.load ? 1'b0 : claimed_nxt;
      proc_v_r     <= ctrl.rd_en;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
      if (emit) begin
        pend_v_r     <= 1'b1;
        out_strobe_r <= pend_v_r;
      end else if (ctrl.flush && pend_v_r) begin
        pend_v_r     <= 1'b0;
        out_strobe_r <= 1'b1;
        out_last_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= rd_idx;
    if (ctrl.load) begin
      cmd_r       <= lbs_pkg::cmd_t'(in_cmd);
      new_led_r   <= in_led_index;
      new_red_r   <= in_red;
      new_green_r <= in_green;
      new_blue_r  <= in_blue;
      new_count_r <= in_blink_count;
      new_on_r    <= in_on_frames;
      new_off_r   <= in_off_frames;
    end
    if (emit || ctrl.flush) begin
      out_led_r   <= pend_led_r;
      out_red_r   <= pend_red_r;
      out_green_r <= pend_green_r;
      out_blue_r  <= pend_blue_r;
    end
    if (emit) begin
      pend_led_r   <= q_led;
      pend_red_r   <= emit_red;
      pend_green_r <= emit_green;
      pend_blue_r  <= emit_blue;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_last          = out_last_r;
  assign out_led_index_res = out_led_r;
  assign out_red_res       = out_red_r;
  assign out_green_res     = out_green_r;
  assign out_blue_res      = out_blue_r;

  `ASSERT_NEVER(a_flush_proc, ctrl.flush && proc_v_r, "flush overlaps slot processing")
  `ASSERT_IMPLY(a_last_strobe, out_last, out_strobe, "last marked without a result")
  `ASSERT_NEXT(a_emit_pending, emit, pend_v_r, "emitted write not held pending")

endmodule

[hw/rtl/multi_slot_led_blink_scheduler.sv]
// Top level of the multi-slot LED blink scheduler.
//
// Command channel: an item (start, tick or stop-all, with its start fields)
// is taken at a rising edge where start is high and busy is low.
// Each item scans all SLOTS slots one per cycle through the slot RAMs;
// busy stays high through the scan, drain and flush states, so a new
// item is taken only once the slot scan of the last one is finished.
// Result channel: each color write shows on the out_ ports for one cycle
// with out_strobe high; out_last marks the final write of an item.
// Writes come in slot order, each held in a pending register until a later
// write or the flush; the last appears in the first cycle with busy low.
// Start and unused codes give no writes; a tick gives one per active slot;
// stop-all gives exactly SLOTS writes, all black.
// The receiver cannot stall: every strobed write is taken as shown.
// Reset (rst_n low, synchronous) frees every slot, marks slot contents
// unwritten so they read as zero; the block is ready right after reset.
module multi_slot_led_blink_scheduler #(
  parameter int SLOTS = lbs_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_cmd,
  input  logic [lbs_pkg::LED_W-1:0]   in_led_index,
  input  logic [lbs_pkg::COLOR_W-1:0] in_red,
  input  logic [lbs_pkg::COLOR_W-1:0] in_green,
  input  logic [lbs_pkg::COLOR_W-1:0] in_blue,
  input  logic [lbs_pkg::CNT_W-1:0]   in_blink_count,
  input  logic [lbs_pkg::CNT_W-1:0]   in_on_frames,
  input  logic [lbs_pkg::CNT_W-1:0]   in_off_frames,
  output logic                        out_strobe,
  output logic [lbs_pkg::LED_W-1:0]   out_led_index_res,
  output logic [lbs_pkg::COLOR_W-1:0] out_red_res,
  output logic [lbs_pkg::COLOR_W-1:0] out_green_res,
  output logic [lbs_pkg::COLOR_W-1:0] out_blue_res,
  output logic                        out_last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  lbs_pkg::dp_ctrl_t ctrl;
  logic [IDX_W-1:0]  rd_idx;

  lbs_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .ctrl   (ctrl),
    .rd_idx (rd_idx)
  );

  lbs_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .rd_idx            (rd_idx),
    .in_cmd            (in_cmd),
    .in_led_index      (in_led_index),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_blink_count    (in_blink_count),
    .in_on_frames      (in_on_frames),
    .in_off_frames     (in_off_frames),
    .out_strobe        (out_strobe),
    .out_led_index_res (out_led_index_res),
    .out_red_res       (out_red_res),
    .out_green_res     (out_green_res),
    .out_blue_res      (out_blue_res),
    .out_last          (out_last)
  );

endmodule

[tb/sv/blink_write_checker.sv]
// Checker for the blink scheduler: predicts each color write and compares it with the block.
module blink_write_checker #(
  parameter int SLOTS = lbs_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  in_cmd,
  input  logic [lbs_pkg::LED_W-1:0]   in_led_index,
  input  logic [lbs_pkg::COLOR_W-1:0] in_red,
  input  logic [lbs_pkg::COLOR_W-1:0] in_green,
  input  logic [lbs_pkg::COLOR_W-1:0] in_blue,
  input  logic [lbs_pkg::CNT_W-1:0]   in_blink_count,
  input  logic [lbs_pkg::CNT_W-1:0]   in_on_frames,
  input  logic [lbs_pkg::CNT_W-1:0]   in_off_frames,
  input  logic                        out_strobe,
  input  logic [lbs_pkg::LED_W-1:0]   out_led_index_res,
  input  logic [lbs_pkg::COLOR_W-1:0] out_red_res,
  input  logic [lbs_pkg::COLOR_W-1:0] out_green_res,
  input  logic [lbs_pkg::COLOR_W-1:0] out_blue_res,
  input  logic                        out_last,
  output int                          fail_count,
  output int                          pending_count,
  output int                          write_count,
  output int                          drop_count
);
  import lbs_pkg::*;

  typedef struct packed {
    logic [LED_W-1:0]   led;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } color_write_t;

  color_write_t pending_writes[$];

  logic [LED_W-1:0]   led_tab[SLOTS];
  logic [COLOR_W-1:0] red_tab[SLOTS];
  logic [COLOR_W-1:0] green_tab[SLOTS];
  logic [COLOR_W-1:0] blue_tab[SLOTS];
  logic [CNT_W-1:0]   remain_tab[SLOTS];
  logic [CNT_W-1:0]   on_tab[SLOTS];
  logic [CNT_W-1:0]   off_tab[SLOTS];
  logic [CNT_W-1:0]   ticks_tab[SLOTS];
  logic               active_tab[SLOTS];
  logic               lit_tab[SLOTS];

  int n_fail = 0;
  int n_write = 0;
  int n_drop = 0;

  task automatic clear_table();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      led_tab[i] = '0;
      red_tab[i] = '0;
      green_tab[i] = '0;
      blue_tab[i] = '0;
      remain_tab[i] = '0;
      on_tab[i] = '0;
      off_tab[i] = '0;
      ticks_tab[i] = '0;
      active_tab[i] = 1'b0;
      lit_tab[i] = 1'b0;
    end
  endtask

  task automatic push_write(input logic [LED_W-1:0] led, input logic [COLOR_W-1:0] r,
                            input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    color_write_t w;
    w = '{led: led, red: r, green: g, blue: b, last: 1'b0};
    pending_writes.push_back(w);
  endtask

  task automatic schedule_writes(input cmd_t cmd, input logic [LED_W-1:0] led,
                                 input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                                 input logic [COLOR_W-1:0] b, input logic [CNT_W-1:0] blinks,
                                 input logic [CNT_W-1:0] on_len, input logic [CNT_W-1:0] off_len);
    int i;
    int queued;
    bit placed;
    color_write_t w;
    queued = pending_writes.size();
    placed = 1'b0;
    case (cmd)
      CMD_START: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!placed && !active_tab[i]) begin
            led_tab[i] = led;
            red_tab[i] = r;
            green_tab[i] = g;
            blue_tab[i] = b;
            remain_tab[i] = blinks;
            on_tab[i] = on_len;
            off_tab[i] = off_len;
            ticks_tab[i] = '0;
            active_tab[i] = 1'b1;
            lit_tab[i] = 1'b1;
            placed = 1'b1;
          end
        end
        if (!placed) n_drop++;
      end
      CMD_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (active_tab[i]) begin
            ticks_tab[i] = ticks_tab[i] + 1'b1;
            if (lit_tab[i]) begin
              if (ticks_tab[i] >= on_tab[i]) begin
                ticks_tab[i] = '0;
                lit_tab[i] = 1'b0;
                if (remain_tab[i] != 0) begin
                  remain_tab[i] = remain_tab[i] - 1'b1;
                  if (remain_tab[i] == 0) active_tab[i] = 1'b0;
                end
              end
            end else if (ticks_tab[i] >= off_tab[i]) begin
              ticks_tab[i] = '0;
              lit_tab[i] = 1'b1;
            end
            if (lit_tab[i]) push_write(led_tab[i], red_tab[i], green_tab[i], blue_tab[i]);
            else push_write(led_tab[i], '0, '0, '0);
          end
        end
      end
      CMD_STOP: begin
        for (i = 0; i < SLOTS; i++) begin
          push_write(led_tab[i], '0, '0, '0);
          active_tab[i] = 1'b0;
          lit_tab[i] = 1'b0;
          ticks_tab[i] = '0;
          remain_tab[i] = '0;
        end
      end
      default: begin
      end
    endcase
    if (pending_writes.size() > queued) begin
      w = pending_writes.pop_back();
      w.last = 1'b1;
      pending_writes.push_back(w);
    end
  endtask

  task automatic check_write();
    color_write_t got;
    color_write_t want;
    got = '{led: out_led_index_res, red: out_red_res, green: out_green_res,
            blue: out_blue_res, last: out_last};
    n_write++;
    if (pending_writes.size() == 0) begin
      n_fail++;
      if (n_fail <= 10)
        $display("unexpected write: led=%0d rgb=%0d,%0d,%0d last=%0b",
                 got.led, got.red, got.green, got.blue, got.last);
    end else begin
      want = pending_writes.pop_front();
      if (got.led !== want.led || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.last !== want.last) begin
        n_fail++;
        if (n_fail <= 10) begin
          $write("write %0d: expected led=%0d rgb=%0d,%0d,%0d last=%0b, ",
                 n_write, want.led, want.red, want.green, want.blue, want.last);
          $display("got led=%0d rgb=%0d,%0d,%0d last=%0b",
                   got.led, got.red, got.green, got.blue, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
      pending_writes.delete();
    end else begin
      if (out_strobe) check_write();
      if (start && !busy)
        schedule_writes(cmd_t'(in_cmd), in_led_index, in_red, in_green, in_blue,
                        in_blink_count, in_on_frames, in_off_frames);
    end
    fail_count <= n_fail;
    pending_count <= pending_writes.size();
    write_count <= n_write;
    drop_count <= n_drop;
  end

endmodule

[tb/sv/testbench.sv]
// Top of the blink scheduler testbench: clock, reset, command stimulus and verdict.
module testbench;
  import lbs_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int RANDOM_ITEMS = 480;
  localparam int CALM_TAIL = 60;
  localparam int QUIET_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_cmd;
  logic [LED_W-1:0]   in_led_index;
  logic [COLOR_W-1:0] in_red;
  logic [COLOR_W-1:0] in_green;
  logic [COLOR_W-1:0] in_blue;
  logic [CNT_W-1:0]   in_blink_count;
  logic [CNT_W-1:0]   in_on_frames;
  logic [CNT_W-1:0]   in_off_frames;
  logic               out_strobe;
  logic [LED_W-1:0]   out_led_index_res;
  logic [COLOR_W-1:0] out_red_res;
  logic [COLOR_W-1:0] out_green_res;
  logic [COLOR_W-1:0] out_blue_res;
  logic               out_last;

  int fail_count;
  int pending_count;
  int write_count;
  int drop_count;

  int n_start = 0;
  int n_tick = 0;
  int n_stop = 0;
  int quiet_cycles;

  always #1 clk = ~clk;

  multi_slot_led_blink_scheduler #(.SLOTS(SLOTS)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_led_index(in_led_index), .in_red(in_red), .in_green(in_green),
    .in_blue(in_blue), .in_blink_count(in_blink_count), .in_on_frames(in_on_frames),
    .in_off_frames(in_off_frames), .out_strobe(out_strobe),
    .out_led_index_res(out_led_index_res), .out_red_res(out_red_res),
    .out_green_res(out_green_res), .out_blue_res(out_blue_res), .out_last(out_last)
  );

  blink_write_checker #(.SLOTS(SLOTS)) u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_led_index(in_led_index), .in_red(in_red), .in_green(in_green),
    .in_blue(in_blue), .in_blink_count(in_blink_count), .in_on_frames(in_on_frames),
    .in_off_frames(in_off_frames), .out_strobe(out_strobe),
    .out_led_index_res(out_led_index_res), .out_red_res(out_red_res),
    .out_green_res(out_green_res), .out_blue_res(out_blue_res), .out_last(out_last),
    .fail_count(fail_count), .pending_count(pending_count),
    .write_count(write_count), .drop_count(drop_count)
  );

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic issue(input cmd_t c, input logic [LED_W-1:0] led,
                       input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                       input logic [COLOR_W-1:0] b, input logic [CNT_W-1:0] blinks,
                       input logic [CNT_W-1:0] on_len, input logic [CNT_W-1:0] off_len);
    start <= 1'b1;
    in_cmd <= c;
    in_led_index <= led;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_blink_count <= blinks;
    in_on_frames <= on_len;
    in_off_frames <= off_len;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (c)
      CMD_START: n_start++;
      CMD_TICK:  n_tick++;
      CMD_STOP:  n_stop++;
      default: begin
      end
    endcase
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [CNT_W-1:0] pick_frames();
    if ($urandom_range(0, 11) == 0) return CNT_W'($urandom);
    return CNT_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [CNT_W-1:0] pick_blinks();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return CNT_W'($urandom);
    if (sel <= 3) return '0;
    return CNT_W'($urandom_range(1, 4));
  endfunction

  task automatic issue_random(output bit counted);
    int sel;
    cmd_t c;
    sel = $urandom_range(0, 99);
    if (sel < 30) c = CMD_START;
    else if (sel < 88) c = CMD_TICK;
    else if (sel < 95) c = CMD_STOP;
    else c = CMD_NONE;
    issue(c, LED_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
          pick_blinks(), pick_frames(), pick_frames());
    counted = (c != CMD_NONE);
  endtask

  initial begin
    int sent;
    int phase_left;
    bit idle_phase;
    bit counted;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= CMD_NONE;
    in_led_index <= '0;
    in_red <= '0;
    in_green <= '0;
    in_blue <= '0;
    in_blink_count <= '0;
    in_on_frames <= '0;
    in_off_frames <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    issue(CMD_TICK, 8'd7, 8'd1, 8'd2, 8'd3, 16'd1, 16'd1, 16'd1);
    issue(CMD_STOP, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    issue(CMD_NONE, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff);
    issue(CMD_START, 8'hff, 8'hff, 8'hff, 8'hff, 16'd1, 16'd0, 16'd0);
    issue(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 16'hffff, 16'hffff);
    issue(CMD_START, 8'h5a, 8'h80, 8'h01, 8'hfe, 16'hffff, 16'd1, 16'd2);
    repeat (3) issue(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0);
    issue(CMD_START, 8'h10, 8'h11, 8'h12, 8'h13, 16'd2, 16'd0, 16'd1);
    issue(CMD_START, 8'h20, 8'h21, 8'h22, 8'h23, 16'd3, 16'd2, 16'd0);
    issue(CMD_START, 8'h30, 8'h31, 8'h32, 8'h33, 16'd0, 16'd1, 16'd1);
    issue(CMD_START, 8'h40, 8'h41, 8'h42, 8'h43, 16'd1, 16'd3, 16'd3);
    issue(CMD_START, 8'h50, 8'h51, 8'h52, 8'h53, 16'd4, 16'd0, 16'd0);
    issue(CMD_START, 8'h60, 8'h61, 8'h62, 8'h63, 16'd0, 16'd2, 16'd2);
    issue(CMD_START, 8'h70, 8'h71, 8'h72, 8'h73, 16'd5, 16'd1, 16'd1);
    repeat (2) issue(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0);
    issue(CMD_STOP, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0);

    sent = 0;
    idle_phase = 1'b1;
    phase_left = $urandom_range(20, 60);
    while (sent < RANDOM_ITEMS) begin
      issue_random(counted);
      if (counted) sent++;
      if (phase_left == 0) begin
        idle_phase = !idle_phase;
        phase_left = $urandom_range(20, 60);
      end else begin
        phase_left--;
      end
      if (idle_phase && sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 2) == 0)
        pause($urandom_range(1, 10));
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SLOTS + 6) @(posedge clk);

    $display("covered %0d starts (%0d dropped on a full table), %0d ticks, %0d stop-alls",
             n_start, drop_count, n_tick, n_stop);
    $display("checked %0d colour writes, %0d mismatches", write_count, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
